@@ rtl/core/lnc_pkg.sv @@
// lnc_pkg: widths, constants, register indexes and the base period table
// for the LFSR noise channel. No dependencies.
package lnc_pkg;

    localparam int SR_W           = 18;
    localparam int IDX_W          = 4;
    localparam int PERIOD_ENTRIES = 16;
    localparam int BASE_W         = 12;
    localparam int PROD_W         = SR_W + BASE_W;
    localparam int GAIN_W         = 16;
    localparam int PER_W          = 15;
    localparam int CNT_W          = 15;
    localparam int SHIFT_W        = 15;
    localparam int CFG_IDX_W      = 1;

    // floor(x / 44750) as (x * RECIP) >> RECIP_SHIFT, low by at most one
    localparam int DIV_W          = 16;
    localparam int RECIP_W        = 31;
    localparam int RECIP_SHIFT    = 46;
    localparam int REM_W          = PROD_W + 1;
    localparam logic [DIV_W-1:0]   CLOCK_DIVISOR = 16'd44750;
    localparam logic [RECIP_W-1:0] RECIP         = 31'd1572485903;

    localparam logic [SR_W-1:0]    SR_RESET      = 18'd48000;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET   = 15'h0001;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MODE   = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic signed [GAIN_W-1:0] gain;
        logic [PER_W-1:0]         period;
    } lnc_item_t;

    function automatic logic [BASE_W-1:0] base_period(input logic [IDX_W-1:0] idx);
        logic [BASE_W-1:0] b;
        unique case (idx)
            4'd0:  b = 12'd4068;
            4'd1:  b = 12'd2034;
            4'd2:  b = 12'd1016;
            4'd3:  b = 12'd762;
            4'd4:  b = 12'd508;
            4'd5:  b = 12'd380;
            4'd6:  b = 12'd254;
            4'd7:  b = 12'd202;
            4'd8:  b = 12'd160;
            4'd9:  b = 12'd128;
            4'd10: b = 12'd96;
            4'd11: b = 12'd64;
            4'd12: b = 12'd32;
            4'd13: b = 12'd16;
            4'd14: b = 12'd8;
            4'd15: b = 12'd4;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/core/lnc_if.sv @@
// lnc_if: valid/ready channel interfaces for sample requests and results.
// Depends on lnc_pkg.
interface lnc_sample_if import lnc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic [IDX_W-1:0]         period_index;
    logic signed [GAIN_W-1:0] gain;

    modport source (output valid, mode, period_index, gain, input ready);
    modport sink   (input valid, mode, period_index, gain, output ready);
endinterface

interface lnc_result_if import lnc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     noise_bit;
    logic signed [GAIN_W-1:0] level;

    modport source (output valid, noise_bit, level, input ready);
    modport sink   (input valid, noise_bit, level, output ready);
endinterface

@@ rtl/core/lnc_period.sv @@
// lnc_period: four-stage pipeline that registers a sample request and works out
// its timer period, max(floor(sample_rate * base / 44750), 1). Depends on lnc_pkg.
module lnc_period import lnc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SR_W-1:0]   sample_rate,
    lnc_sample_if.sink        sample,
    output logic              item_valid,
    input  logic              item_ready,
    output lnc_item_t         item
);

    // stage 1: input register
    logic                     v1_reg;
    logic                     mode1_reg;
    logic [IDX_W-1:0]         idx1_reg;
    logic signed [GAIN_W-1:0] gain1_reg;
    // stage 2: sample_rate * base
    logic                     v2_reg;
    logic                     mode2_reg;
    logic signed [GAIN_W-1:0] gain2_reg;
    logic [PROD_W-1:0]        prod2_reg;
    // stage 3: quotient estimate
    logic                     v3_reg;
    logic                     mode3_reg;
    logic signed [GAIN_W-1:0] gain3_reg;
    logic [PROD_W-1:0]        prod3_reg;
    logic [PER_W-1:0]         q3_reg;
    // stage 4: corrected period
    logic                     v4_reg;
    lnc_item_t                item4_reg;

    logic rdy1, rdy2, rdy3, rdy4;
    logic [PROD_W-1:0]             prod_next;
    logic [PROD_W+RECIP_W-1:0]     recip_prod;
    logic [PER_W-1:0]              q_next;
    logic [REM_W-1:0]              q_times_d;
    logic [REM_W-1:0]              rem;
    logic [PER_W-1:0]              q_fix;
    logic [PER_W-1:0]              period_next;

    assign rdy4 = !v4_reg || item_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign sample.ready = rdy1;

    assign prod_next  = PROD_W'(sample_rate) * PROD_W'(base_period(idx1_reg));
    assign recip_prod = (PROD_W+RECIP_W)'(prod2_reg) * (PROD_W+RECIP_W)'(RECIP);
    assign q_next     = recip_prod[RECIP_SHIFT +: PER_W];

    assign q_times_d  = REM_W'(q3_reg) * REM_W'(CLOCK_DIVISOR);
    assign rem        = REM_W'(prod3_reg) - q_times_d;
    assign q_fix      = (rem >= REM_W'(CLOCK_DIVISOR)) ? q3_reg + PER_W'(1) : q3_reg;
    assign period_next = (q_fix == '0) ? PER_W'(1) : q_fix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= sample.valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && sample.valid)
        begin
            mode1_reg <= sample.mode;
            idx1_reg  <= sample.period_index;
            gain1_reg <= sample.gain;
        end
        if (rdy2 && v1_reg)
        begin
            mode2_reg <= mode1_reg;
            gain2_reg <= gain1_reg;
            prod2_reg <= prod_next;
        end
        if (rdy3 && v2_reg)
        begin
            mode3_reg <= mode2_reg;
            gain3_reg <= gain2_reg;
            prod3_reg <= prod2_reg;
            q3_reg    <= q_next;
        end
        if (rdy4 && v3_reg)
        begin
            item4_reg.mode   <= mode3_reg;
            item4_reg.gain   <= gain3_reg;
            item4_reg.period <= period_next;
        end
    end

    assign item_valid = v4_reg;
    assign item       = item4_reg;

endmodule

@@ rtl/core/lnc_noise_core.sv @@
// lnc_noise_core: tick counter, 15-bit shift register and result register.
// Depends on lnc_pkg and lnc_result_if.
module lnc_noise_core import lnc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        long_mode,
    input  logic        restart,
    input  logic        item_valid,
    output logic        item_ready,
    input  lnc_item_t   item,
    lnc_result_if.source result
);

    logic [SHIFT_W-1:0]       shift_reg, shift_next;
    logic [CNT_W-1:0]         tick_reg, tick_next;
    logic                     out_valid_reg;
    logic                     noise_bit_reg;
    logic signed [GAIN_W-1:0] level_reg;

    logic                     take;
    logic                     emit;
    logic [CNT_W:0]           tick_inc;
    logic                     tap;
    logic                     feedback;

    assign item_ready = !out_valid_reg || result.ready;
    assign take       = item_valid && item_ready;
    assign emit       = take && !item.mode;

    assign tick_inc = {1'b0, tick_reg} + (CNT_W+1)'(1);
    assign tap      = long_mode ? shift_reg[6] : shift_reg[1];
    assign feedback = shift_reg[0] ^ tap;

    always_comb
    begin
        if (tick_inc >= (CNT_W+1)'(item.period))
        begin
            tick_next  = '0;
            shift_next = {feedback, shift_reg[SHIFT_W-1:1]};
        end
        else
        begin
            tick_next  = tick_inc[CNT_W-1:0];
            shift_next = shift_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg     <= SHIFT_RESET;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (restart || (take && item.mode))
            begin
                shift_reg <= SHIFT_RESET;
                tick_reg  <= '0;
            end
            else if (emit)
            begin
                shift_reg <= shift_next;
                tick_reg  <= tick_next;
            end

            if (emit)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            noise_bit_reg <= shift_reg[0];
            level_reg     <= shift_reg[0] ? item.gain : '0;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.noise_bit = noise_bit_reg;
    assign result.level     = level_reg;

endmodule

@@ rtl/core/lfsr_noise_channel.sv @@
// lfsr_noise_channel: top level of the periodic LFSR noise channel.
// Holds the configuration registers; instantiates lnc_period and lnc_noise_core.
// Depends on lnc_pkg and lnc_if.
//
//  channel   direction  payload                        handshake
//  sample    in         mode, period_index, gain       valid/ready
//  result    out        noise_bit, level               valid/ready
//  cfg       in         cfg_index, cfg_data            cfg_we, no ready
//
// One request per cycle is taken while the stages are not held by a waiting
// result; a request is registered in the input register when accepted, then
// passes through the multiply, reciprocal multiply and correction stages and
// the counter/shift update into the result register.
// A release request (mode = 1) restarts counter and shift register and
// gives no result. Every stage has its own valid bit, so bubbles collapse
// and new requests enter while a finished result waits on result.ready.
// Reset: sample_rate 48000, long_mode 0, counter 0, shift register 1.
module lfsr_noise_channel import lnc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    lnc_sample_if.sink           sample,
    lnc_result_if.source         result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SR_W-1:0]      cfg_data
);

    logic [SR_W-1:0] sample_rate_reg;
    logic            long_mode_reg;
    logic            restart;

    logic            item_valid;
    logic            item_ready;
    lnc_item_t       item;

    // A sample_rate write also restarts the noise generator.
    assign restart = cfg_we && (cfg_index == CFG_SAMPLE_RATE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg <= SR_RESET;
            long_mode_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SAMPLE_RATE: sample_rate_reg <= cfg_data;
                CFG_LONG_MODE:   long_mode_reg   <= cfg_data[0];
            endcase
        end
    end

    // Period lookup: base table times sample rate, divided by 44750.
    lnc_period u_period (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_rate (sample_rate_reg),
        .sample      (sample),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item)
    );

    // Counter, LFSR and the result register.
    lnc_noise_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .long_mode  (long_mode_reg),
        .restart    (restart),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .result     (result)
    );

endmodule

@@ verif/lnc_noise_tb_pkg.sv @@
// lnc_noise_tb_pkg: request codes, result record and the result tracker for
// the noise channel testbench. Depends on lnc_pkg.
package lnc_noise_tb_pkg;
    import lnc_pkg::*;

    localparam logic MODE_SAMPLE  = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;
    localparam longint unsigned TICK_DIVISOR = 44750;

    typedef struct packed {
        logic                     noise_bit;
        logic signed [GAIN_W-1:0] level;
    } noise_result_t;

    class lfsr_level_scoreboard;
        logic [SR_W-1:0]    rate;
        logic               long_taps;
        logic [SHIFT_W-1:0] lfsr;
        logic [CNT_W-1:0]   ticks;
        int unsigned        base_ticks [PERIOD_ENTRIES];
        noise_result_t      pending_levels [$];
        int unsigned        errors;
        int unsigned        samples;
        int unsigned        releases;
        int unsigned        checked;
        int unsigned        reg_writes;

        function new();
            base_ticks = '{4068, 2034, 1016, 762, 508, 380, 254, 202,
                           160, 128, 96, 64, 32, 16, 8, 4};
            rate       = SR_RESET;
            long_taps  = 1'b0;
            errors     = 0;
            samples    = 0;
            releases   = 0;
            checked    = 0;
            reg_writes = 0;
            restart();
        endfunction

        function void restart();
            lfsr  = SHIFT_RESET;
            ticks = '0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] reg_index,
                                input logic [SR_W-1:0] data);
            reg_writes++;
            if (reg_index == CFG_SAMPLE_RATE)
            begin
                rate = data;
                restart();
            end
            else
            begin
                long_taps = data[0];
            end
        endfunction

        // exact floor(rate * base / 44750), never below one tick
        function int unsigned timer_period(input logic [IDX_W-1:0] idx);
            longint unsigned p;
            p = 64'(rate);
            p = (p * base_ticks[idx]) / TICK_DIVISOR;
            if (p == 0)
                p = 1;
            return p[31:0];
        endfunction

        function void note_request(input logic mode, input logic [IDX_W-1:0] idx,
                                   input logic signed [GAIN_W-1:0] gain);
            noise_result_t r;
            int unsigned   next_ticks;
            logic          tap;
            if (mode == MODE_RELEASE)
            begin
                releases++;
                restart();
                return;
            end
            samples++;
            r.noise_bit = lfsr[0];
            r.level     = lfsr[0] ? gain : '0;
            pending_levels.push_back(r);
            next_ticks = ticks + 1;
            if (next_ticks >= timer_period(idx))
            begin
                tap        = long_taps ? lfsr[6] : lfsr[1];
                lfsr       = {lfsr[0] ^ tap, lfsr[SHIFT_W-1:1]};
                next_ticks = 0;
            end
            ticks = next_ticks[CNT_W-1:0];
        endfunction

        function void check_result(input logic noise_bit,
                                   input logic signed [GAIN_W-1:0] level);
            noise_result_t want;
            if (pending_levels.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing pending: bit %0b level %0d",
                         $time, noise_bit, level);
                return;
            end
            want = pending_levels.pop_front();
            checked++;
            if (noise_bit !== want.noise_bit)
            begin
                errors++;
                $display("%0t: noise_bit expected %0b actual %0b",
                         $time, want.noise_bit, noise_bit);
            end
            if (level !== want.level)
            begin
                errors++;
                $display("%0t: level expected %0d actual %0d", $time, want.level, level);
            end
        endfunction

        function int unsigned pending();
            return pending_levels.size();
        endfunction

        function void check_drained();
            if (pending_levels.size() != 0)
            begin
                errors++;
                $display("%0t: %0d results never arrived", $time, pending_levels.size());
            end
        endfunction
    endclass

endpackage

@@ verif/lfsr_noise_channel_tb.sv @@
// lfsr_noise_channel_tb: drives sample and release requests into the noise
// channel and checks every result against a cycle-free tracker.
// Depends on lnc_pkg, lnc_if and lnc_noise_tb_pkg.
module lfsr_noise_channel_tb;
    import lnc_pkg::*;
    import lnc_noise_tb_pkg::*;

    // pipeline is five deep; release requests leave no result behind, so
    // the settle time covers them before any register write
    localparam int SETTLE_CYCLES   = 12;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 400000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SR_W-1:0]      cfg_data;

    lnc_sample_if sample_req();
    lnc_result_if noise_res();

    lfsr_noise_channel u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_req),
        .result    (noise_res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lfsr_level_scoreboard sb;

    bit               send_idle;     // sender inserts random gaps
    bit               recv_idle;     // receiver inserts random stalls
    bit               hold_off_req;  // receiver goes quiet for a long stretch
    int unsigned      cycles;
    logic [IDX_W-1:0] cur_idx;       // period index tends to stick for a while

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("end of test: mismatches");
        $finish;
    end

    // result monitor: values sampled at the edge are the pre-edge ones
    always @(posedge clk)
    begin
        if (rst_n && noise_res.valid && noise_res.ready)
            sb.check_result(noise_res.noise_bit, noise_res.level);
    end

    // result receiver: random stall per result, or one long hold-off on request
    initial
    begin
        int unsigned stall;
        noise_res.ready = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                noise_res.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                stall = recv_idle ? $urandom_range(0, 19) : 0;
                if (stall > 0)
                begin
                    noise_res.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            noise_res.ready <= 1'b1;
            do @(posedge clk); while (!(noise_res.valid && noise_res.ready) && !hold_off_req);
        end
    end

    // one request; valid stays up across back-to-back requests
    task automatic send_request(input logic mode, input logic [IDX_W-1:0] idx,
                                input logic signed [GAIN_W-1:0] gain);
        int unsigned gap;
        gap = send_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            sample_req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_req.valid        <= 1'b1;
        sample_req.mode         <= mode;
        sample_req.period_index <= idx;
        sample_req.gain         <= gain;
        do @(posedge clk); while (!sample_req.ready);
        sb.note_request(mode, idx, gain);
    endtask

    // sender stops until every result is back and the pipe has emptied
    task automatic drain();
        sample_req.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // long_mode alone never restarts the channel, so it may go in by itself
    task automatic configure(input bit with_rate, input logic [SR_W-1:0] rate,
                             input logic [SR_W-1:0] taps);
        cfg_we <= 1'b1;
        if (with_rate)
        begin
            cfg_index <= CFG_SAMPLE_RATE;
            cfg_data  <= rate;
            @(posedge clk);
            sb.write_reg(CFG_SAMPLE_RATE, rate);
        end
        cfg_index <= CFG_LONG_MODE;
        cfg_data  <= taps;
        @(posedge clk);
        sb.write_reg(CFG_LONG_MODE, taps);
        cfg_we <= 1'b0;
    endtask

    // tap select word with junk in the unused upper bits
    function automatic logic [SR_W-1:0] tap_word(input logic on);
        logic [SR_W-1:0] w;
        w    = SR_W'($urandom);
        w[0] = on;
        return w;
    endfunction

    // samples with occasional releases; the index drifts, mostly to fast ones
    task automatic random_phase(input int unsigned n, input int unsigned release_pct);
        logic                     mode;
        logic signed [GAIN_W-1:0] gain;
        int unsigned              roll;
        for (int unsigned i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
                cur_idx = IDX_W'($urandom_range(0, 15));
            else if (roll < 20)
                cur_idx = IDX_W'($urandom_range(12, 15));
            mode = ($urandom_range(0, 99) < release_pct) ? MODE_RELEASE : MODE_SAMPLE;
            case ($urandom_range(0, 9))
                0:       gain = 16'sh7FFF;
                1:       gain = 16'sh8000;
                default: gain = GAIN_W'($urandom);
            endcase
            send_request(mode, cur_idx, gain);
        end
    endtask

    initial
    begin
        logic [SR_W-1:0] rate;
        sb = new();
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = CFG_SAMPLE_RATE;
        cfg_data                = '0;
        sample_req.valid        = 1'b0;
        sample_req.mode         = MODE_SAMPLE;
        sample_req.period_index = '0;
        sample_req.gain         = '0;
        send_idle               = 1'b1;
        recv_idle               = 1'b1;
        hold_off_req            = 1'b0;
        cur_idx                 = 4'd15;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: 48000 Hz, short taps; fastest index shifts every 4th
        send_request(MODE_SAMPLE, 4'd15, 16'sh7FFF);
        send_request(MODE_SAMPLE, 4'd15, 16'sh8000);
        send_request(MODE_SAMPLE, 4'd15, 16'sh0000);
        send_request(MODE_SAMPLE, 4'd15, 16'shFFFF);
        send_request(MODE_SAMPLE, 4'd15, 16'sh7FFF);
        // count builds up on the slowest index, then a fast index sees it over
        for (int i = 0; i < 6; i++)
            send_request(MODE_SAMPLE, 4'd0, 16'sh1234);
        send_request(MODE_SAMPLE, 4'd15, 16'sh5A5A);
        send_request(MODE_SAMPLE, 4'd15, 16'shA5A5);
        // release restarts counter and register; back-to-back releases too
        send_request(MODE_RELEASE, 4'd7, 16'sh5555);
        send_request(MODE_SAMPLE, 4'd14, 16'sh0001);
        send_request(MODE_RELEASE, 4'd0, 16'sh8000);
        send_request(MODE_RELEASE, 4'd15, 16'sh7FFF);
        send_request(MODE_SAMPLE, 4'd15, 16'shFFFF);
        send_request(MODE_SAMPLE, 4'd8, 16'sh4000);
        send_request(MODE_SAMPLE, 4'd15, 16'sh3FFF);

        // lowest rate: every period floors to zero and is raised to one
        drain();
        configure(1'b1, 18'd1, tap_word(1'b1));
        random_phase(130, 5);

        // highest stated rate, short taps, no idling on either side
        drain();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        configure(1'b1, 18'd192000, tap_word(1'b0));
        cur_idx = 4'd15;
        random_phase(130, 2);

        // field extremes beyond the stated range
        drain();
        send_idle = 1'b1;
        recv_idle = 1'b1;
        configure(1'b1, 18'h3FFFF, tap_word(1'b1));
        random_phase(100, 3);
        drain();
        configure(1'b1, 18'd0, tap_word(1'b0));
        random_phase(100, 6);

        // receiver goes quiet while the sender keeps pushing: the pipe fills
        // and sample.ready must drop; afterwards the sender waits for all results
        drain();
        send_idle    = 1'b0;
        recv_idle    = 1'b1;
        configure(1'b1, 18'd11000, tap_word(1'b1));
        hold_off_req = 1'b1;
        random_phase(80, 3);
        drain();

        // tap change alone, state carried over from the burst
        send_idle = 1'b1;
        configure(1'b0, '0, tap_word(1'b0));
        random_phase(60, 0);

        // random rates, biased low so the register moves often
        for (int k = 0; k < 4; k++)
        begin
            drain();
            rate = ($urandom_range(0, 1) == 0) ? SR_W'($urandom_range(1, 20000))
                                               : SR_W'($urandom_range(1, 192000));
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            configure(1'b1, rate, tap_word(1'($urandom_range(0, 1))));
            random_phase(110, 4);
        end

        drain();
        sb.check_drained();
        $display("ran %0d sample and %0d release requests over %0d register writes",
                 sb.samples, sb.releases, sb.reg_writes);
        $display("%0d results compared, %0d errors", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
